// ===== sv/nearest_neighbor_chain_clustering_defines.svh =====
// Assertion macros for the clustering block.
// Included by the top level; depends on nothing.
`ifndef NEAREST_NEIGHBOR_CHAIN_CLUSTERING_DEFINES_SVH
`define NEAREST_NEIGHBOR_CHAIN_CLUSTERING_DEFINES_SVH
`ifndef SYNTH
`define NNC_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("check failed");
`define NNC_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("check failed");
`else
`define NNC_ASSERT_IMP(lbl, clk, rst, a, c)
`define NNC_ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

// ===== sv/nnc_pkg.sv =====
// Shared types and constants for the clustering block.
// No dependencies.
`timescale 1ns / 1ps
package nnc_pkg;
  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 16;
  localparam logic [10:0] UNLABELED = 11'h7FF;
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_RUN  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_RD0, S_RD1, S_CLR, S_L0, S_NEXT_I, S_CHK_I, S_CHK_I2,
    S_PUSH, S_SRCH_P, S_SRCH_P2, S_SRCH_J, S_SRCH_J2, S_SRCH_ACC,
    S_TEST, S_TEST2, S_FILL, S_FILL2, S_DONE
  } state_t;
endpackage

// ===== sv/nnc_ram.sv =====
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module nnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/nearest_neighbor_chain_clustering.sv =====
// Top level of nearest-neighbor chain clustering.
// Depends on nnc_pkg, nnc_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "nearest_neighbor_chain_clustering_defines.svh"
// Usage:
//   A request word is taken when start is high and busy is low. req_type picks
//   load (append a point), run (cluster all loaded points) or read (label of
//   point_index). Code 3 is dropped.
//   Results appear for one cycle with done high; the receiver cannot stall, so
//   every result is simply presented once.
// Operation:
//   Load writes the point RAM when the request is taken. Read steps through RD0
//   and RD1 (RAM read, then result). Run first sweeps every label RAM entry, then
//   walks chains. Each chain step is a brute-force nearest search over the loaded
//   points through the single coordinate RAM read port; a full run is these
//   searches plus chain writeback.
// Reset:
//   Clears the point count, the cluster count and marks labels as unlabeled
//   through a valid bit: labels count as written only from the first run on,
//   and reads before then return 0 because every point is unlabeled.
module nearest_neighbor_chain_clustering #(
  parameter int MAX_POINTS = nnc_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = nnc_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] coord_z,
  input  logic [9:0]  point_index,
  output logic        done,
  output logic        result_kind,
  output logic [9:0]  result_index,
  output logic [10:0] result_value
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;
  localparam int EB = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int PW = 3 * 16;
  localparam int DW = 2 * 17 + 2;

  nnc_pkg::state_t state, state_next;

  logic [CW-1:0] loaded_count;
  logic [10:0]   cluster_total;
  logic          ran;
  logic [CW-1:0] i_cnt, j_cnt, len, k_cnt;
  logic [AW-1:0] cur, best;
  logic          have;
  logic [DW-1:0] best_d;
  logic signed [16:0] px, py, pz;
  logic [10:0]   lab;
  logic [9:0]    rd_idx;

  // point RAM: x,y,z packed
  logic          pt_we;
  logic [AW-1:0] pt_waddr, pt_raddr;
  logic [PW-1:0] pt_wdata, pt_rdata;
  // label RAM with a chain flag bit on top
  logic          lb_we;
  logic [AW-1:0] lb_waddr, lb_raddr;
  logic [11:0]   lb_wdata, lb_rdata;
  // chain buffer
  logic          ch_we;
  logic [AW-1:0] ch_waddr, ch_raddr;
  logic [AW-1:0] ch_wdata, ch_rdata;

  nnc_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pt (
    .clk, .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata));
  nnc_ram #(.WIDTH(12), .DEPTH(MAX_POINTS)) u_lb (
    .clk, .we(lb_we), .waddr(lb_waddr), .wdata(lb_wdata),
    .raddr(lb_raddr), .rdata(lb_rdata));
  nnc_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_ch (
    .clk, .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rdata));

  function automatic logic signed [16:0] sx(input logic [15:0] v);
    logic [15:0] t;
    t = v << (16 - EB);
    return 17'(signed'(t) >>> (16 - EB));
  endfunction

  // squared distance of the fetched point to the chain head
  logic signed [17:0] dx, dy, dz;
  logic [DW-1:0] dist_sum;
  logic [DW-1:0] dist_r;
  assign dx = 18'(sx(pt_rdata[47:32])) - 18'(px);
  assign dy = 18'(sx(pt_rdata[31:16])) - 18'(py);
  assign dz = 18'(sx(pt_rdata[15:0]))  - 18'(pz);
  assign dist_sum = DW'(dx * dx) + DW'(dy * dy) + DW'(dz * dz);

  logic accept;
  assign busy   = (state != nnc_pkg::S_IDLE);
  assign accept = start && !busy;

  logic lb_is_lab, lb_in_chain;
  assign lb_is_lab   = ran && (lb_rdata[10:0] != nnc_pkg::UNLABELED);
  assign lb_in_chain = lb_rdata[11];

  always_comb begin
    state_next = state;
    unique case (state)
      nnc_pkg::S_IDLE:
        if (accept) begin
          if (req_type == nnc_pkg::REQ_RUN) state_next = nnc_pkg::S_CLR;
          else if (req_type == nnc_pkg::REQ_READ) state_next = nnc_pkg::S_RD0;
        end
      nnc_pkg::S_RD0:     state_next = nnc_pkg::S_RD1;
      nnc_pkg::S_RD1:     state_next = nnc_pkg::S_IDLE;
      nnc_pkg::S_CLR:
        if (k_cnt == CW'(MAX_POINTS - 1)) state_next = nnc_pkg::S_L0;
      nnc_pkg::S_L0:
        state_next = (loaded_count == '0) ? nnc_pkg::S_DONE : nnc_pkg::S_NEXT_I;
      nnc_pkg::S_NEXT_I:
        state_next = (i_cnt >= loaded_count) ? nnc_pkg::S_DONE : nnc_pkg::S_CHK_I;
      nnc_pkg::S_CHK_I:   state_next = nnc_pkg::S_CHK_I2;
      nnc_pkg::S_CHK_I2:
        state_next = lb_is_lab ? nnc_pkg::S_NEXT_I : nnc_pkg::S_PUSH;
      nnc_pkg::S_PUSH:    state_next = nnc_pkg::S_SRCH_P;
      nnc_pkg::S_SRCH_P:  state_next = nnc_pkg::S_SRCH_P2;
      nnc_pkg::S_SRCH_P2: state_next = nnc_pkg::S_SRCH_J;
      nnc_pkg::S_SRCH_J:
        state_next = (j_cnt >= loaded_count) ? nnc_pkg::S_TEST : nnc_pkg::S_SRCH_J2;
      nnc_pkg::S_SRCH_J2: state_next = nnc_pkg::S_SRCH_ACC;
      nnc_pkg::S_SRCH_ACC: state_next = nnc_pkg::S_SRCH_J;
      nnc_pkg::S_TEST:    state_next = nnc_pkg::S_TEST2;
      nnc_pkg::S_TEST2:
        if (lb_is_lab || lb_in_chain || len >= loaded_count)
          state_next = nnc_pkg::S_FILL;
        else state_next = nnc_pkg::S_PUSH;
      nnc_pkg::S_FILL:
        state_next = (k_cnt >= len) ? nnc_pkg::S_NEXT_I : nnc_pkg::S_FILL2;
      nnc_pkg::S_FILL2:   state_next = nnc_pkg::S_FILL;
      nnc_pkg::S_DONE:    state_next = nnc_pkg::S_IDLE;
      default:            state_next = nnc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pt_we = 1'b0; pt_waddr = loaded_count[AW-1:0];
    pt_wdata = {coord_x, coord_y, coord_z};
    pt_raddr = j_cnt[AW-1:0];
    lb_we = 1'b0; lb_waddr = k_cnt[AW-1:0]; lb_wdata = {1'b0, nnc_pkg::UNLABELED};
    lb_raddr = cur;
    ch_we = 1'b0; ch_waddr = len[AW-1:0]; ch_wdata = cur; ch_raddr = k_cnt[AW-1:0];
    unique case (state)
      nnc_pkg::S_IDLE: begin
        lb_raddr = AW'(point_index);
        if (accept && req_type == nnc_pkg::REQ_LOAD && loaded_count < CW'(MAX_POINTS)) begin
          pt_we = 1'b1;
          // keep a fresh point unlabeled once labels are live
          lb_we = ran; lb_waddr = loaded_count[AW-1:0];
        end
      end
      nnc_pkg::S_RD0:    lb_raddr = AW'(rd_idx);
      nnc_pkg::S_CLR:    lb_we = 1'b1;
      nnc_pkg::S_L0: begin
        lb_we = (loaded_count != '0); lb_waddr = '0; lb_wdata = 12'd0;
      end
      nnc_pkg::S_CHK_I:  lb_raddr = i_cnt[AW-1:0];
      nnc_pkg::S_PUSH: begin
        ch_we = 1'b1;
        lb_we = 1'b1; lb_waddr = cur; lb_wdata = {1'b1, nnc_pkg::UNLABELED};
      end
      nnc_pkg::S_SRCH_P: pt_raddr = cur;
      // fetch the label of the winner while cur advances to it
      nnc_pkg::S_TEST:   lb_raddr = best;
      nnc_pkg::S_FILL2: begin
        lb_we = 1'b1; lb_waddr = ch_rdata; lb_wdata = {1'b0, lab};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nnc_pkg::S_IDLE;
      loaded_count <= '0; cluster_total <= '0; ran <= 1'b0; done <= 1'b0;
      k_cnt <= '0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      unique case (state)
        nnc_pkg::S_IDLE:
          if (accept) begin
            rd_idx <= point_index;
            k_cnt <= '0;
            if (req_type == nnc_pkg::REQ_LOAD && loaded_count < CW'(MAX_POINTS))
              loaded_count <= loaded_count + 1'b1;
          end
        nnc_pkg::S_RD1: begin
          done <= 1'b1; result_kind <= 1'b1; result_index <= rd_idx;
          result_value <= (32'(rd_idx) < 32'(loaded_count) && 32'(rd_idx) < MAX_POINTS
                           && lb_is_lab) ? lb_rdata[10:0] : 11'd0;
        end
        nnc_pkg::S_CLR:    k_cnt <= k_cnt + 1'b1;
        nnc_pkg::S_L0: begin
          ran <= 1'b1; i_cnt <= CW'(1);
          cluster_total <= (loaded_count != '0) ? 11'd1 : 11'd0;
        end
        nnc_pkg::S_NEXT_I: begin
          cur <= i_cnt[AW-1:0]; len <= '0;
        end
        // skip a point that an earlier chain already labeled
        nnc_pkg::S_CHK_I2:
          if (lb_is_lab) i_cnt <= i_cnt + 1'b1;
        nnc_pkg::S_PUSH:   len <= len + 1'b1;
        nnc_pkg::S_SRCH_P: begin
          j_cnt <= '0; have <= 1'b0; best <= cur;
        end
        nnc_pkg::S_SRCH_P2: begin
          px <= sx(pt_rdata[47:32]); py <= sx(pt_rdata[31:16]); pz <= sx(pt_rdata[15:0]);
        end
        nnc_pkg::S_SRCH_J2: dist_r <= dist_sum;
        nnc_pkg::S_SRCH_ACC: begin
          if (j_cnt[AW-1:0] != cur && (!have || dist_r < best_d)) begin
            have <= 1'b1; best_d <= dist_r; best <= j_cnt[AW-1:0];
          end
          j_cnt <= j_cnt + 1'b1;
        end
        nnc_pkg::S_TEST:   cur <= best;
        nnc_pkg::S_TEST2: begin
          k_cnt <= '0;
          if (lb_is_lab) lab <= lb_rdata[10:0];
          else if (lb_in_chain || len >= loaded_count) begin
            lab <= cluster_total; cluster_total <= cluster_total + 1'b1;
          end
        end
        nnc_pkg::S_FILL:
          if (k_cnt >= len) i_cnt <= i_cnt + 1'b1;
        nnc_pkg::S_FILL2:  k_cnt <= k_cnt + 1'b1;
        nnc_pkg::S_DONE: begin
          done <= 1'b1; result_kind <= 1'b0; result_index <= '0;
          result_value <= cluster_total;
        end
        default: ;
      endcase
    end
  end

  `NNC_ASSERT_NXT(a_read_busy, clk, rst, accept && req_type == nnc_pkg::REQ_READ, busy)
  `NNC_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `NNC_ASSERT_IMP(a_count_cap, clk, rst, 1'b1, loaded_count <= CW'(MAX_POINTS))
  `NNC_ASSERT_NXT(a_run_busy, clk, rst, accept && req_type == nnc_pkg::REQ_RUN, busy)
endmodule
